>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the bank mapper.
// Depends on nothing; include by bare file name before the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CBM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// An antecedent that implies a consequent at the same edge.
`define CBM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An antecedent that implies a consequent at the next edge.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cbm_pkg.sv
// Package of the cartridge bank mapper: payload structs, bank state and codes.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package cbm_pkg;

    // Field widths of the bus access and of the mapped result.
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned TARGET_W   = 2;
    localparam int unsigned ROM_ADDR_W = 23;
    localparam int unsigned RAM_ADDR_W = 18;
    localparam int unsigned KIND_W     = 2;

    // Widths of the bank registers.
    localparam int unsigned ROM_BANK_W = 9;
    localparam int unsigned RAM_BANK_W = 5;

    // Controller kinds; the unused code behaves as type 1.
    localparam logic [KIND_W-1:0] KIND_TYPE1 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TYPE2 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TYPE5 = 2'd2;

    // Access commands.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result targets.
    localparam logic [TARGET_W-1:0] TARGET_NONE = 2'd0;
    localparam logic [TARGET_W-1:0] TARGET_ROM  = 2'd1;
    localparam logic [TARGET_W-1:0] TARGET_RAM  = 2'd2;

    // One bus access.
    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } access_t;

    // One mapped result.
    typedef struct packed {
        logic [TARGET_W-1:0]   target;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [RAM_ADDR_W-1:0] ram_address;
    } result_t;

    // Bank registers as seen by the address translation.
    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  bank_mode;
    } bank_state_t;

endpackage

>>> rtl/cbm_ifs.sv
// Valid/ready channel interfaces of the bank mapper: bus access in, result out.
// Depends on cbm_pkg for the field widths.
interface cbm_access_if;
    import cbm_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output command, output address, output data,
                    input ready);
    modport sink (input valid, input command, input address, input data,
                  output ready);
endinterface

interface cbm_result_if;
    import cbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TARGET_W-1:0]   target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;

    modport source (output valid, output target, output rom_address,
                    output ram_address, input ready);
    modport sink (input valid, input target, input rom_address,
                  input ram_address, output ready);
endinterface

>>> rtl/cbm_bank_regs.sv
// Bank registers of the mapper: ROM bank, RAM bank and banking mode,
// updated by bus writes to 0x2000-0x7FFF. Depends on cbm_pkg.
module cbm_bank_regs #(
    parameter int unsigned RAM_BANKS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               update,
    input  cbm_pkg::access_t                   item,
    input  logic [cbm_pkg::KIND_W-1:0]         kind,
    output cbm_pkg::bank_state_t               state
);
    import cbm_pkg::*;

    localparam int unsigned MOD_DEPTH = 1 << DATA_W;

    logic [ROM_BANK_W-1:0] rom_bank_reg;
    logic [ROM_BANK_W-1:0] rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg;
    logic [RAM_BANK_W-1:0] ram_bank_next;
    logic                  bank_mode_reg;
    logic                  bank_mode_next;
    logic [RAM_BANK_W-1:0] ram_mod [MOD_DEPTH];
    logic [DATA_W-1:0]     data_nz;
    logic                  is_type5;
    logic                  bank_write;

    // Constant table of the written byte modulo the bank count, low five bits kept.
    for (genvar i = 0; i < MOD_DEPTH; i++) begin : g_mod
        assign ram_mod[i] = RAM_BANK_W'((i % RAM_BANKS) & 31);
    end

    assign is_type5   = (kind == KIND_TYPE5);
    assign bank_write = update && (item.command == CMD_WRITE) && !item.address[15];
    assign data_nz    = (item.data == '0) ? DATA_W'(1) : item.data;

    // Decode of the register write by address range and controller kind.
    always_comb
    begin
        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        bank_mode_next = bank_mode_reg;
        if (bank_write)
        begin
            unique case (item.address[14:13])
                2'b00:
                begin
                    // 0x0000-0x1FFF is ignored; 0x2000-0x3FFF is handled below.
                end
                2'b01:
                begin
                    if (!is_type5)
                        rom_bank_next[4:0] = item.data[4:0];
                    else if (!item.address[12])
                        rom_bank_next[7:0] = item.data;
                    else
                        rom_bank_next[8] = item.data[0];
                end
                2'b10:
                begin
                    if (is_type5 || bank_mode_reg)
                        ram_bank_next = ram_mod[data_nz];
                    else
                        rom_bank_next[6:5] = item.data[1:0];
                end
                2'b11:
                begin
                    bank_mode_next = item.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg  <= ROM_BANK_W'(1);
            ram_bank_reg  <= '0;
            bank_mode_reg <= 1'b0;
        end
        else
        begin
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            bank_mode_reg <= bank_mode_next;
        end
    end

    assign state.rom_bank  = rom_bank_reg;
    assign state.ram_bank  = ram_bank_reg;
    assign state.bank_mode = bank_mode_reg;

endmodule

>>> rtl/cbm_translate.sv
// Address translation of the mapper: maps one bus access to a ROM or RAM
// byte address from the current bank state. Depends on cbm_pkg.
module cbm_translate #(
    parameter int unsigned ROM_BANK_BITS = 9
) (
    input  cbm_pkg::access_t           item,
    input  cbm_pkg::bank_state_t       state,
    input  logic [cbm_pkg::KIND_W-1:0] kind,
    output cbm_pkg::result_t           result
);
    import cbm_pkg::*;

    localparam logic [ROM_BANK_W-1:0] BANK_MASK = ROM_BANK_W'((1 << ROM_BANK_BITS) - 1);

    logic                  is_type1;
    logic [ROM_BANK_W-1:0] masked_bank;
    logic [ROM_BANK_W-1:0] eff_bank;

    assign is_type1 = (kind == KIND_TYPE1) || !(kind == KIND_TYPE2 || kind == KIND_TYPE5);

    // Type 1 never selects a bank that is a multiple of 32; it takes the next one.
    assign masked_bank = state.rom_bank & BANK_MASK;
    assign eff_bank = (is_type1 && (masked_bank[4:0] == 5'd0))
                    ? masked_bank + ROM_BANK_W'(1) : masked_bank;

    // Window decode.
    always_comb
    begin
        result.target      = TARGET_NONE;
        result.rom_address = '0;
        result.ram_address = '0;
        if (!item.address[15])
        begin
            if (item.command == CMD_READ)
            begin
                result.target = TARGET_ROM;
                if (!item.address[14])
                    result.rom_address = ROM_ADDR_W'(item.address[13:0]);
                else
                    result.rom_address = {eff_bank, item.address[13:0]};
            end
        end
        else if (item.address[14:13] == 2'b01)
        begin
            result.target      = TARGET_RAM;
            result.ram_address = {state.ram_bank, item.address[12:0]};
        end
    end

endmodule

>>> rtl/cartridge_bank_mapper.sv
// Cartridge bank mapper, top level. Holds the input and result registers and
// ties the bank registers to the translation. Depends on cbm_pkg, cbm_ifs,
// cbm_bank_regs and cbm_translate.
//
// Usage:
//   req carries one CPU bus access per transaction (command, address, data).
//   rsp carries one result per access (target, rom_address, ram_address),
//   in the order the accesses were taken.
//   cfg_we/cfg_wdata set the controller kind; write it only while idle.
// Timing:
//   An accepted access passes the input register, then the result register, and
//   its result transaction is offered from the result register. A new access is
//   taken in every cycle while no stalled result holds the input register; the bank
//   registers update as an access leaves the input register, so the next
//   access already sees the new banks.
// Reset:
//   Both stages empty, ROM bank 1, RAM bank 0, ROM banking mode, type 1.
// Stalls:
//   While rsp.ready is low the result holds; the input register still takes
//   one more access, after which req.ready drops until the result is taken.
module cartridge_bank_mapper #(
    parameter int unsigned RAM_BANKS     = 32,
    parameter int unsigned ROM_BANK_BITS = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cbm_access_if.sink                 req,
    cbm_result_if.source               rsp,
    input  logic                       cfg_we,
    input  logic [cbm_pkg::KIND_W-1:0] cfg_wdata
);
    import cbm_pkg::*;

    logic [KIND_W-1:0] kind_reg;
    logic              s1_valid_reg;
    access_t           s1_item_reg;
    logic              s2_valid_reg;
    result_t           s2_result_reg;
    logic              req_accept;
    logic              s1_advance;
    access_t           req_item;
    bank_state_t       bank_state;
    result_t           mapped;

    assign req_item.command = req.command;
    assign req_item.address = req.address;
    assign req_item.data    = req.data;

    // Handshake between the two stages.
    assign s1_advance = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign req_accept = req.valid && req.ready;

    // Controller kind register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= KIND_TYPE1;
        else if (cfg_we)
            kind_reg <= cfg_wdata;
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
            if (s1_advance)
                s2_valid_reg <= 1'b1;
            else if (rsp.ready)
                s2_valid_reg <= 1'b0;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (req_accept)
            s1_item_reg <= req_item;
        if (s1_advance)
            s2_result_reg <= mapped;
    end

    cbm_bank_regs #(
        .RAM_BANKS (RAM_BANKS)
    ) u_bank_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (s1_advance),
        .item   (s1_item_reg),
        .kind   (kind_reg),
        .state  (bank_state)
    );

    cbm_translate #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_translate (
        .item   (s1_item_reg),
        .state  (bank_state),
        .kind   (kind_reg),
        .result (mapped)
    );

    assign rsp.valid       = s2_valid_reg;
    assign rsp.target      = s2_result_reg.target;
    assign rsp.rom_address = s2_result_reg.rom_address;
    assign rsp.ram_address = s2_result_reg.ram_address;

endmodule

>>> rtl/cbm_checker.sv
// Port checker of the cartridge bank mapper and its bind to the top level.
// Depends on cbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [cbm_pkg::TARGET_W-1:0]   target,
    input logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address,
    input logic [cbm_pkg::RAM_ADDR_W-1:0] ram_address
);
    import cbm_pkg::*;

    // A stalled result transaction keeps its payload.
    `CBM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(target) && $stable(rom_address) && $stable(ram_address), "stalled result changed")

    // A ready receiver always lets the input side take an access.
    `CBM_ASSERT_SAME(a_ready_flow, clk, rst_n, rsp_ready, req_ready, "input blocked with receiver ready")

    // Only the address of the chosen target may be non-zero.
    `CBM_ASSERT_SAME(a_addr_select, clk, rst_n, rsp_valid, (target == TARGET_ROM || rom_address == '0) && (target == TARGET_RAM || ram_address == '0), "address of unselected target set")

    // Only the three defined targets are reported.
    `CBM_ASSERT_SAME(a_target_code, clk, rst_n, rsp_valid, target == TARGET_NONE || target == TARGET_ROM || target == TARGET_RAM, "undefined target code")

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .target      (rsp.target),
    .rom_address (rsp.rom_address),
    .ram_address (rsp.ram_address)
);
